// ===== design/svwm_pkg.sv =====
// Shared widths, codes and limits for the supply voltage window monitor.
// No dependencies; every other design file refers to it by scoped names.

package svwm_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int NOW_W      = 32;
    localparam int AVG_W      = 15;
    localparam int TGT_W      = 2;
    localparam int IND_W      = 3;
    localparam int HUE_W      = 7;
    localparam int WARN_W     = 2;
    localparam int MODE_W     = 2;
    localparam int HOLD_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE_SELECT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_HIGH_MV  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_LOW_MV   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MINOR_HOLDOFF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAJOR_HOLDOFF = 3'd4;

    // Register reset values
    localparam logic [AVG_W-1:0]  AUTO_HIGH_RST     = 15'd4300;
    localparam logic [AVG_W-1:0]  AUTO_LOW_RST      = 15'd2700;
    localparam logic [HOLD_W-1:0] MINOR_HOLDOFF_RST = 16'd20000;
    localparam logic [HOLD_W-1:0] MAJOR_HOLDOFF_RST = 16'd10000;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_AUTO  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_3V3   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_5V    = 2'd3;

    // Target codes
    localparam logic [TGT_W-1:0] TGT_OFF = 2'd0;
    localparam logic [TGT_W-1:0] TGT_3V3 = 2'd1;
    localparam logic [TGT_W-1:0] TGT_5V  = 2'd2;

    // Indicator codes
    localparam logic [IND_W-1:0] IND_OFF    = 3'd0;
    localparam logic [IND_W-1:0] IND_STEADY = 3'd1;
    localparam logic [IND_W-1:0] IND_HALF   = 3'd2;
    localparam logic [IND_W-1:0] IND_FLASH  = 3'd3;
    localparam logic [IND_W-1:0] IND_DOUBLE = 3'd4;

    // Warning codes
    localparam logic [WARN_W-1:0] WARN_NONE  = 2'd0;
    localparam logic [WARN_W-1:0] WARN_MINOR = 2'd1;
    localparam logic [WARN_W-1:0] WARN_MAJOR = 2'd2;

    // Nominal levels and class limits on the deviation in mV.
    // 3.3 V uses a 250 mV spread, 5 V a 100 mV spread; the limits are
    // 0.3, 0.5 and 1.2 times the spread.
    localparam logic [AVG_W-1:0] GOAL_3V3_MV  = 15'd3300;
    localparam logic [AVG_W-1:0] GOAL_5V_MV   = 15'd5000;
    localparam logic [AVG_W-1:0] STEADY_3V3   = 15'd75;
    localparam logic [AVG_W-1:0] HALF_3V3     = 15'd125;
    localparam logic [AVG_W-1:0] FLASH_3V3    = 15'd300;
    localparam logic [AVG_W-1:0] STEADY_5V    = 15'd30;
    localparam logic [AVG_W-1:0] HALF_5V      = 15'd50;
    localparam logic [AVG_W-1:0] FLASH_5V     = 15'd120;

    localparam int               DEV_CLAMP_W  = 9;
    localparam logic [AVG_W-1:0] DEV_CLAMP    = 15'd511;
    localparam logic [15:0]      HUE_SLOPE    = 16'd60;
    localparam logic [15:0]      HUE_MAX      = 16'd120;
    localparam logic [15:0]      SPREAD_3V3   = 16'd250;
    localparam logic [15:0]      SPREAD_5V    = 16'd100;

    // Reciprocals of the spreads; exact for every numerator below 2^15
    localparam logic [31:0]      RECIP_3V3    = 32'd33555;
    localparam int               RECIP_SH_3V3 = 23;
    localparam logic [31:0]      RECIP_5V     = 32'd41944;
    localparam int               RECIP_SH_5V  = 22;

    localparam int AVG_MAX = 32767;

    typedef struct packed {
        logic [IND_W-1:0] indicator;
        logic [HUE_W-1:0] hue;
        logic             minor_band;
        logic             major_band;
    } grade_t;

endpackage

// ===== design/svwm_if.sv =====
// Valid/ready channel interfaces for samples and results.
// Depends on svwm_pkg for field widths.

interface svwm_in_if;
    logic                         valid;
    logic                         ready;
    logic [svwm_pkg::SAMPLE_W-1:0] sample_mv;
    logic [svwm_pkg::NOW_W-1:0]    now_ticks;

    modport source (output valid, output sample_mv, output now_ticks, input ready);
    modport sink   (input valid, input sample_mv, input now_ticks, output ready);
endinterface

interface svwm_out_if;
    logic                        valid;
    logic                        ready;
    logic [svwm_pkg::AVG_W-1:0]  avg_vcc_mv;
    logic [svwm_pkg::TGT_W-1:0]  target_sel;
    logic                        target_changed;
    logic [svwm_pkg::IND_W-1:0]  indicator;
    logic [svwm_pkg::HUE_W-1:0]  hue;
    logic [svwm_pkg::WARN_W-1:0] warning;

    modport source (output valid, output avg_vcc_mv, output target_sel,
                    output target_changed, output indicator, output hue,
                    output warning, input ready);
    modport sink   (input valid, input avg_vcc_mv, input target_sel,
                    input target_changed, input indicator, input hue,
                    input warning, output ready);
endinterface

// ===== design/svwm_grade.sv =====
// Deviation grading: indicator class, hue and warning bands for one average.
// Depends on svwm_pkg for codes, limits and grade_t.

module svwm_grade
(
    input  logic [svwm_pkg::AVG_W-1:0] avg_mv,
    input  logic [svwm_pkg::TGT_W-1:0] target,
    output svwm_pkg::grade_t           grade
);

    logic [svwm_pkg::AVG_W-1:0]       goal;
    logic [svwm_pkg::AVG_W-1:0]       dev;
    logic [svwm_pkg::DEV_CLAMP_W-1:0] dev_c;
    logic [15:0]                      scaled;
    logic [31:0]                      drop_prod;
    logic [15:0]                      drop;
    logic [svwm_pkg::AVG_W-1:0]       lim_steady;
    logic [svwm_pkg::AVG_W-1:0]       lim_half;
    logic [svwm_pkg::AVG_W-1:0]       lim_flash;
    logic                             is_3v3;

    assign is_3v3     = (target == svwm_pkg::TGT_3V3);
    assign goal       = is_3v3 ? svwm_pkg::GOAL_3V3_MV : svwm_pkg::GOAL_5V_MV;
    assign lim_steady = is_3v3 ? svwm_pkg::STEADY_3V3 : svwm_pkg::STEADY_5V;
    assign lim_half   = is_3v3 ? svwm_pkg::HALF_3V3 : svwm_pkg::HALF_5V;
    assign lim_flash  = is_3v3 ? svwm_pkg::FLASH_3V3 : svwm_pkg::FLASH_5V;

    assign dev = (avg_mv > goal) ? (avg_mv - goal) : (goal - avg_mv);

    // Beyond the clamp the hue is zero for either spread
    assign dev_c  = (dev > svwm_pkg::DEV_CLAMP) ? svwm_pkg::DEV_CLAMP[svwm_pkg::DEV_CLAMP_W-1:0]
                                                : dev[svwm_pkg::DEV_CLAMP_W-1:0];
    assign scaled = 16'(dev_c) * svwm_pkg::HUE_SLOPE;

    // Round the drop up, as the hue is floored; divide by the spread
    // through a reciprocal multiply and shift
    always_comb
    begin
        if (is_3v3)
        begin
            drop_prod = 32'(scaled + (svwm_pkg::SPREAD_3V3 - 16'd1)) * svwm_pkg::RECIP_3V3;
            drop      = 16'(drop_prod >> svwm_pkg::RECIP_SH_3V3);
        end
        else
        begin
            drop_prod = 32'(scaled + (svwm_pkg::SPREAD_5V - 16'd1)) * svwm_pkg::RECIP_5V;
            drop      = 16'(drop_prod >> svwm_pkg::RECIP_SH_5V);
        end
    end

    always_comb
    begin
        grade = '0;
        if (target != svwm_pkg::TGT_OFF)
        begin
            if (drop >= svwm_pkg::HUE_MAX)
            begin
                grade.hue = '0;
            end
            else
            begin
                grade.hue = svwm_pkg::HUE_W'(svwm_pkg::HUE_MAX - drop);
            end

            if (dev < lim_steady)
            begin
                grade.indicator = svwm_pkg::IND_STEADY;
            end
            else if (dev < lim_half)
            begin
                grade.indicator = svwm_pkg::IND_HALF;
            end
            else if (dev < lim_flash)
            begin
                grade.indicator  = svwm_pkg::IND_FLASH;
                grade.minor_band = 1'b1;
            end
            else
            begin
                grade.indicator  = svwm_pkg::IND_DOUBLE;
                grade.major_band = 1'b1;
            end
        end
    end

endmodule

// ===== design/supply_voltage_window_monitor.sv =====
// Top level of the supply voltage window monitor: averaging ring, target pick,
// grading and rate-limited warnings. Depends on svwm_pkg, svwm_if.sv, svwm_grade.
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+------------------------------------------
//   samples   | in  | valid/ready   | sample_mv, now_ticks
//   results   | out | valid/ready   | avg_vcc_mv, target_sel, target_changed,
//             |     |               | indicator, hue, warning
//   cfg       | in  | cfg_we        | cfg_index, cfg_data (no read-back)
//
// One sample is taken every cycle unless results back up; each result passes through the
// sum stage, the average stage and the result register before it can transfer.
// The ring is a shift line, so the entry leaving the sum is always at its last tap.
// Reset clears the ring, the sum, the target memory and the last warning time at once.
// A stalled result holds in the result register while two more samples move up behind it.

module supply_voltage_window_monitor
#(
    parameter int AVG_DEPTH = 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    svwm_in_if.sink                           samples,
    svwm_out_if.source                        results,
    input  logic                              cfg_we,
    input  logic [svwm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [svwm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SUM_W   = svwm_pkg::SAMPLE_W + $clog2(AVG_DEPTH);
    localparam int PROD_W  = SUM_W + 3;
    localparam int SUM_MAX = ((1 << svwm_pkg::SAMPLE_W) - 1) * AVG_DEPTH;

    // Configuration
    logic [svwm_pkg::MODE_W-1:0] mode_reg;
    logic [svwm_pkg::AVG_W-1:0]  auto_high_reg;
    logic [svwm_pkg::AVG_W-1:0]  auto_low_reg;
    logic [svwm_pkg::HOLD_W-1:0] minor_holdoff_reg;
    logic [svwm_pkg::HOLD_W-1:0] major_holdoff_reg;

    // Ring and sum
    logic [svwm_pkg::SAMPLE_W-1:0] ring_reg [AVG_DEPTH];
    logic [SUM_W-1:0]              sum_reg;
    logic [SUM_W-1:0]              sum_next;

    // Pipeline
    logic                        a_valid_reg, a_valid_next;
    logic                        b_valid_reg, b_valid_next;
    logic                        c_valid_reg, c_valid_next;
    logic [SUM_W-1:0]            a_sum_reg;
    logic [svwm_pkg::NOW_W-1:0]  a_now_reg;
    logic [svwm_pkg::AVG_W-1:0]  b_avg_reg;
    logic [svwm_pkg::NOW_W-1:0]  b_now_reg;
    logic                        a_ready, b_ready, c_ready;
    logic                        in_fire, a_move, b_move;

    logic [PROD_W-1:0]           prod;
    logic [PROD_W-1:0]           quot;
    logic [svwm_pkg::AVG_W-1:0]  avg_next;

    // Result stage
    logic [svwm_pkg::TGT_W-1:0]  auto_target_reg;
    logic [svwm_pkg::TGT_W-1:0]  auto_next;
    logic [svwm_pkg::TGT_W-1:0]  target_next;
    logic                        changed_next;
    logic [svwm_pkg::NOW_W-1:0]  last_warned_reg;
    logic [svwm_pkg::NOW_W-1:0]  minor_limit;
    logic [svwm_pkg::NOW_W-1:0]  major_limit;
    logic [svwm_pkg::WARN_W-1:0] warn_next;
    svwm_pkg::grade_t            grade;

    logic [svwm_pkg::AVG_W-1:0]  avg_out_reg;
    logic [svwm_pkg::TGT_W-1:0]  target_out_reg;
    logic                        changed_out_reg;
    logic [svwm_pkg::IND_W-1:0]  ind_out_reg;
    logic [svwm_pkg::HUE_W-1:0]  hue_out_reg;
    logic [svwm_pkg::WARN_W-1:0] warn_out_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= svwm_pkg::MODE_AUTO;
            auto_high_reg     <= svwm_pkg::AUTO_HIGH_RST;
            auto_low_reg      <= svwm_pkg::AUTO_LOW_RST;
            minor_holdoff_reg <= svwm_pkg::MINOR_HOLDOFF_RST;
            major_holdoff_reg <= svwm_pkg::MAJOR_HOLDOFF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                svwm_pkg::REG_MODE_SELECT:   mode_reg          <= cfg_data[svwm_pkg::MODE_W-1:0];
                svwm_pkg::REG_AUTO_HIGH_MV:  auto_high_reg     <= cfg_data[svwm_pkg::AVG_W-1:0];
                svwm_pkg::REG_AUTO_LOW_MV:   auto_low_reg      <= cfg_data[svwm_pkg::AVG_W-1:0];
                svwm_pkg::REG_MINOR_HOLDOFF: minor_holdoff_reg <= cfg_data;
                svwm_pkg::REG_MAJOR_HOLDOFF: major_holdoff_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign c_ready = !c_valid_reg || results.ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;

    assign samples.ready = a_ready;
    assign in_fire       = samples.valid && a_ready;
    assign a_move        = a_valid_reg && b_ready;
    assign b_move        = b_valid_reg && c_ready;

    assign a_valid_next = in_fire ? 1'b1 : (a_move ? 1'b0 : a_valid_reg);
    assign b_valid_next = a_move  ? 1'b1 : (b_move ? 1'b0 : b_valid_reg);
    assign c_valid_next = b_move  ? 1'b1 : (results.ready ? 1'b0 : c_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    // ---------------- ring and running sum ----------------
    assign sum_next = sum_reg - SUM_W'(ring_reg[AVG_DEPTH-1]) + SUM_W'(samples.sample_mv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            for (int i = 0; i < AVG_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else if (in_fire)
        begin
            sum_reg     <= sum_next;
            ring_reg[0] <= samples.sample_mv;
            for (int i = 1; i < AVG_DEPTH; i++)
            begin
                ring_reg[i] <= ring_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_sum_reg <= sum_next;
            a_now_reg <= samples.now_ticks;
        end
    end

    // ---------------- average ----------------
    assign prod     = PROD_W'(a_sum_reg) * PROD_W'(5);
    assign quot     = PROD_W'(prod / AVG_DEPTH);
    assign avg_next = (quot > PROD_W'(svwm_pkg::AVG_MAX)) ? svwm_pkg::AVG_W'(svwm_pkg::AVG_MAX)
                                                         : quot[svwm_pkg::AVG_W-1:0];

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            b_avg_reg <= avg_next;
            b_now_reg <= a_now_reg;
        end
    end

    // ---------------- target, grade, warning ----------------
    always_comb
    begin
        if (b_avg_reg > auto_high_reg)
        begin
            auto_next = svwm_pkg::TGT_5V;
        end
        else if (b_avg_reg > auto_low_reg)
        begin
            auto_next = svwm_pkg::TGT_3V3;
        end
        else
        begin
            auto_next = svwm_pkg::TGT_OFF;
        end

        changed_next = 1'b0;
        case (mode_reg)
            svwm_pkg::MODE_AUTO:
            begin
                target_next  = auto_next;
                changed_next = (auto_next != auto_target_reg);
            end
            svwm_pkg::MODE_OFF: target_next = svwm_pkg::TGT_OFF;
            svwm_pkg::MODE_3V3: target_next = svwm_pkg::TGT_3V3;
            svwm_pkg::MODE_5V:  target_next = svwm_pkg::TGT_5V;
            default:            target_next = svwm_pkg::TGT_OFF;
        endcase
    end

    svwm_grade u_grade
    (
        .avg_mv (b_avg_reg),
        .target (target_next),
        .grade  (grade)
    );

    // Limits wrap at 32 bits
    assign minor_limit = last_warned_reg + svwm_pkg::NOW_W'(minor_holdoff_reg);
    assign major_limit = last_warned_reg + svwm_pkg::NOW_W'(major_holdoff_reg);

    always_comb
    begin
        if (grade.minor_band && (b_now_reg > minor_limit))
        begin
            warn_next = svwm_pkg::WARN_MINOR;
        end
        else if (grade.major_band && (b_now_reg > major_limit))
        begin
            warn_next = svwm_pkg::WARN_MAJOR;
        end
        else
        begin
            warn_next = svwm_pkg::WARN_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_target_reg <= svwm_pkg::TGT_OFF;
            last_warned_reg <= '0;
        end
        else if (b_move)
        begin
            if (mode_reg == svwm_pkg::MODE_AUTO)
            begin
                auto_target_reg <= auto_next;
            end
            if (warn_next != svwm_pkg::WARN_NONE)
            begin
                last_warned_reg <= b_now_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_move)
        begin
            avg_out_reg     <= b_avg_reg;
            target_out_reg  <= target_next;
            changed_out_reg <= changed_next;
            ind_out_reg     <= grade.indicator;
            hue_out_reg     <= grade.hue;
            warn_out_reg    <= warn_next;
        end
    end

    assign results.valid          = c_valid_reg;
    assign results.avg_vcc_mv     = avg_out_reg;
    assign results.target_sel     = target_out_reg;
    assign results.target_changed = changed_out_reg;
    assign results.indicator      = ind_out_reg;
    assign results.hue            = hue_out_reg;
    assign results.warning        = warn_out_reg;

    // ---------------- assertions ----------------
    a_off_is_dark : assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && target_out_reg == svwm_pkg::TGT_OFF) |->
        (ind_out_reg == svwm_pkg::IND_OFF && hue_out_reg == '0 &&
         warn_out_reg == svwm_pkg::WARN_NONE))
        else $error("target off but indicator, hue or warning set");

    a_change_auto_only : assert property (@(posedge clk) disable iff (!rst_n)
        (b_move && mode_reg != svwm_pkg::MODE_AUTO) |=> !changed_out_reg)
        else $error("target change flagged outside auto mode");

    a_warn_stamps : assert property (@(posedge clk) disable iff (!rst_n)
        (b_move && warn_next != svwm_pkg::WARN_NONE) |=>
        (last_warned_reg == $past(b_now_reg)))
        else $error("warning given without updating last warning time");

    a_sum_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (32'(sum_reg) <= 32'(SUM_MAX)))
        else $error("running sum beyond ring capacity");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for supply_voltage_window_monitor: drives samples with random
// gaps, predicts each result in a software model of the monitor and compares per field.
// Depends on design/svwm_pkg.sv, design/svwm_if.sv and the monitor RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int RING_DEPTH  = 8;
    localparam int LATENCY     = 3;
    localparam int LONG_HOLD   = 60;
    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic [svwm_pkg::AVG_W-1:0]  avg;
        logic [svwm_pkg::TGT_W-1:0]  target;
        logic                        changed;
        logic [svwm_pkg::IND_W-1:0]  indicator;
        logic [svwm_pkg::HUE_W-1:0]  hue;
        logic [svwm_pkg::WARN_W-1:0] warning;
    } reading_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [svwm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [svwm_pkg::CFG_DATA_W-1:0] cfg_data;

    svwm_in_if  in_ch ();
    svwm_out_if out_ch ();

    supply_voltage_window_monitor u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (in_ch),
        .results   (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Monitor model state and register shadows
    logic [svwm_pkg::SAMPLE_W-1:0] mon_ring [RING_DEPTH];
    int unsigned                   mon_pos;
    int unsigned                   mon_sum;
    logic [svwm_pkg::TGT_W-1:0]    mon_auto_tgt;
    logic [svwm_pkg::NOW_W-1:0]    mon_last_warn;
    logic [svwm_pkg::MODE_W-1:0]   shadow_mode;
    logic [svwm_pkg::AVG_W-1:0]    shadow_high;
    logic [svwm_pkg::AVG_W-1:0]    shadow_low;
    logic [svwm_pkg::HOLD_W-1:0]   shadow_minor;
    logic [svwm_pkg::HOLD_W-1:0]   shadow_major;

    reading_t                   expected_readings [$];
    int unsigned                error_count = 0;
    int unsigned                stall_cycles = 0;
    logic [svwm_pkg::NOW_W-1:0] tick_now = '0;
    bit                         src_idle_en = 1'b1;
    bit                         sink_idle_en = 1'b1;
    bit                         sink_hold_req = 1'b0;

    task automatic reset_monitor_model();
        for (int i = 0; i < RING_DEPTH; i++)
            mon_ring[i] = '0;
        mon_pos       = 0;
        mon_sum       = 0;
        mon_auto_tgt  = svwm_pkg::TGT_OFF;
        mon_last_warn = '0;
        shadow_mode   = svwm_pkg::MODE_AUTO;
        shadow_high   = svwm_pkg::AUTO_HIGH_RST;
        shadow_low    = svwm_pkg::AUTO_LOW_RST;
        shadow_minor  = svwm_pkg::MINOR_HOLDOFF_RST;
        shadow_major  = svwm_pkg::MAJOR_HOLDOFF_RST;
    endtask

    function automatic reading_t predict_reading(input logic [svwm_pkg::SAMPLE_W-1:0] sample,
                                                 input logic [svwm_pkg::NOW_W-1:0] now);
        reading_t                   r;
        int unsigned                avg;
        int unsigned                goal;
        int unsigned                spread;
        int unsigned                dev;
        int unsigned                drop;
        logic [svwm_pkg::TGT_W-1:0] tgt;
        logic [svwm_pkg::TGT_W-1:0] next_tgt;
        logic [svwm_pkg::NOW_W-1:0] limit;
        r = '0;
        mon_sum = mon_sum - mon_ring[mon_pos] + sample;
        mon_ring[mon_pos] = sample;
        mon_pos = (mon_pos + 1) % RING_DEPTH;

        avg = (mon_sum * 5) / RING_DEPTH;
        if (avg > svwm_pkg::AVG_MAX)
            avg = svwm_pkg::AVG_MAX;
        r.avg = svwm_pkg::AVG_W'(avg);

        if (shadow_mode == svwm_pkg::MODE_AUTO)
        begin
            if (avg > shadow_high)
                next_tgt = svwm_pkg::TGT_5V;
            else if (avg > shadow_low)
                next_tgt = svwm_pkg::TGT_3V3;
            else
                next_tgt = svwm_pkg::TGT_OFF;
            r.changed    = (next_tgt != mon_auto_tgt);
            mon_auto_tgt = next_tgt;
            tgt          = next_tgt;
        end
        else
            tgt = svwm_pkg::TGT_W'(shadow_mode - 1);
        r.target = tgt;

        // Target off leaves indicator, hue and warning at zero
        if (tgt != svwm_pkg::TGT_OFF)
        begin
            goal   = (tgt == svwm_pkg::TGT_3V3) ? 3300 : 5000;
            spread = (tgt == svwm_pkg::TGT_3V3) ? 250 : 100;
            dev    = (avg > goal) ? avg - goal : goal - avg;
            drop   = (dev * 60 + spread - 1) / spread;
            r.hue  = (drop >= 120) ? '0 : svwm_pkg::HUE_W'(120 - drop);
            if (dev * 10 < 3 * spread)
                r.indicator = svwm_pkg::IND_STEADY;
            else if (dev * 2 < spread)
                r.indicator = svwm_pkg::IND_HALF;
            else if (dev * 10 < 12 * spread)
            begin
                r.indicator = svwm_pkg::IND_FLASH;
                limit = mon_last_warn + shadow_minor;
                if (now > limit)
                begin
                    mon_last_warn = now;
                    r.warning     = svwm_pkg::WARN_MINOR;
                end
            end
            else
            begin
                r.indicator = svwm_pkg::IND_DOUBLE;
                limit = mon_last_warn + shadow_major;
                if (now > limit)
                begin
                    mon_last_warn = now;
                    r.warning     = svwm_pkg::WARN_MAJOR;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        if (error_count <= 40)
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Result checker
    always @(posedge clk)
    begin : check_results
        reading_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_readings.size() == 0)
                report_mismatch("result transfer with nothing pending", 1, 0);
            else
            begin
                want = expected_readings.pop_front();
                if (out_ch.avg_vcc_mv !== want.avg)
                    report_mismatch("avg_vcc_mv", out_ch.avg_vcc_mv, want.avg);
                if (out_ch.target_sel !== want.target)
                    report_mismatch("target_sel", out_ch.target_sel, want.target);
                if (out_ch.target_changed !== want.changed)
                    report_mismatch("target_changed", out_ch.target_changed, want.changed);
                if (out_ch.indicator !== want.indicator)
                    report_mismatch("indicator", out_ch.indicator, want.indicator);
                if (out_ch.hue !== want.hue)
                    report_mismatch("hue", out_ch.hue, want.hue);
                if (out_ch.warning !== want.warning)
                    report_mismatch("warning", out_ch.warning, want.warning);
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("[supply_voltage_window_monitor] ERROR");
                $finish;
            end
        end
    end

    // Result receiver: random stall bursts, plus one long hold on request
    initial
    begin : result_sink
        int hold;
        hold = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                out_ch.ready <= 1'b0;
            end
            else if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                hold = LONG_HOLD - 1;
                out_ch.ready <= 1'b0;
            end
            else if (sink_idle_en && $urandom_range(0, 7) == 0)
            begin
                hold = int'($urandom_range(1, 15)) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic send_sample(input logic [svwm_pkg::SAMPLE_W-1:0] sample,
                               input logic [svwm_pkg::NOW_W-1:0] now);
        int gap;
        if (src_idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = int'($urandom_range(1, 15));
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid     <= 1'b1;
        in_ch.sample_mv <= sample;
        in_ch.now_ticks <= now;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_readings.push_back(predict_reading(sample, now));
    endtask

    // Drop valid and hold until every pending result has been taken
    task automatic pause_sender();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle_block();
        pause_sender();
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_register(input logic [svwm_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [svwm_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            svwm_pkg::REG_MODE_SELECT:   shadow_mode  = data[svwm_pkg::MODE_W-1:0];
            svwm_pkg::REG_AUTO_HIGH_MV:  shadow_high  = data[svwm_pkg::AVG_W-1:0];
            svwm_pkg::REG_AUTO_LOW_MV:   shadow_low   = data[svwm_pkg::AVG_W-1:0];
            svwm_pkg::REG_MINOR_HOLDOFF: shadow_minor = data[svwm_pkg::HOLD_W-1:0];
            svwm_pkg::REG_MAJOR_HOLDOFF: shadow_major = data[svwm_pkg::HOLD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [svwm_pkg::CFG_DATA_W-1:0] mode,
                                  input logic [svwm_pkg::CFG_DATA_W-1:0] high,
                                  input logic [svwm_pkg::CFG_DATA_W-1:0] low,
                                  input logic [svwm_pkg::CFG_DATA_W-1:0] minor,
                                  input logic [svwm_pkg::CFG_DATA_W-1:0] major);
        settle_block();
        write_register(svwm_pkg::REG_MODE_SELECT, mode);
        write_register(svwm_pkg::REG_AUTO_HIGH_MV, high);
        write_register(svwm_pkg::REG_AUTO_LOW_MV, low);
        write_register(svwm_pkg::REG_MINOR_HOLDOFF, minor);
        write_register(svwm_pkg::REG_MAJOR_HOLDOFF, major);
    endtask

    // Runs of samples around the two nominal levels and the auto thresholds, with noise
    task automatic run_random(input int count);
        int regime;
        int left;
        int level;
        left   = 0;
        regime = 0;
        for (int i = 0; i < count; i++)
        begin
            if (left == 0)
            begin
                regime = int'($urandom_range(0, 9));
                left   = int'($urandom_range(4, 20));
            end
            left--;
            case (regime)
                0, 1, 2: level = 600 + int'($urandom_range(0, 120));
                3, 4, 5: level = 970 + int'($urandom_range(0, 60));
                6:       level = int'($urandom_range(0, 4095));
                7:       level = int'($urandom_range(0, 3300));
                8:       level = $urandom_range(0, 1) ? 4095 : 0;
                default: level = ($urandom_range(0, 1) ? 520 : 840) + int'($urandom_range(0, 40));
            endcase
            case ($urandom_range(0, 19))
                0:       tick_now = $urandom();
                1:       tick_now = 32'hFFFF_FFFF - $urandom_range(0, 20000);
                default: tick_now = tick_now + $urandom_range(0, 9000);
            endcase
            send_sample(svwm_pkg::SAMPLE_W'(level), tick_now);
        end
    endtask

    task automatic test_extremes();
        send_sample(12'd0, 32'h0000_0000);
        send_sample(12'hFFF, 32'hFFFF_FFFF);
        send_sample(12'hFFF, 32'h0000_0000);
        send_sample(12'hFFF, 32'd20001);
        // one tick exactly at the end of the hold-off, then one past it
        send_sample(12'hFFF, 32'd30001);
        send_sample(12'hFFF, 32'd30002);
        // hold-off sum wraps past 2^32
        send_sample(12'hFFF, 32'hFFFF_F000);
        send_sample(12'hFFF, 32'd100);
        send_sample(12'hFFF, 32'd6000);
        send_sample(12'd0, 32'd7000);
        send_sample(12'd0, 32'd8000);
    endtask

    task automatic test_fixed_modes();
        settle_block();
        write_register(svwm_pkg::REG_MODE_SELECT, svwm_pkg::CFG_DATA_W'(svwm_pkg::MODE_OFF));
        send_sample(12'd660, 32'd50000);
        send_sample(12'd660, 32'd60000);
        settle_block();
        write_register(svwm_pkg::REG_MODE_SELECT, svwm_pkg::CFG_DATA_W'(svwm_pkg::MODE_3V3));
        send_sample(12'd660, 32'd70000);
        send_sample(12'd700, 32'd95000);
        send_sample(12'd900, 32'd120000);
        settle_block();
        write_register(svwm_pkg::REG_MODE_SELECT, svwm_pkg::CFG_DATA_W'(svwm_pkg::MODE_5V));
        send_sample(12'd1000, 32'd130000);
        send_sample(12'd1000, 32'd140000);
        send_sample(12'hFFF, 32'd160000);
        // auto resumes from the target it held before the fixed modes
        settle_block();
        write_register(svwm_pkg::REG_MODE_SELECT, svwm_pkg::CFG_DATA_W'(svwm_pkg::MODE_AUTO));
        send_sample(12'd1000, 32'd170000);
        send_sample(12'd0, 32'd180000);
    endtask

    task automatic test_zero_holdoff();
        apply_settings(svwm_pkg::CFG_DATA_W'(svwm_pkg::MODE_AUTO),
                       svwm_pkg::CFG_DATA_W'(svwm_pkg::AUTO_HIGH_RST),
                       svwm_pkg::CFG_DATA_W'(svwm_pkg::AUTO_LOW_RST), 16'd0, 16'd0);
        run_random(60);
    endtask

    task automatic test_threshold_extremes();
        apply_settings(svwm_pkg::CFG_DATA_W'(svwm_pkg::MODE_AUTO), 16'd16500, 16'd0,
                       16'hFFFF, 16'hFFFF);
        run_random(30);
        pause_sender();
        run_random(30);
    endtask

    task automatic test_backpressure();
        apply_settings(svwm_pkg::CFG_DATA_W'(svwm_pkg::MODE_AUTO), 16'd0, 16'd0,
                       16'd3000, 16'd1500);
        src_idle_en   = 1'b0;
        sink_hold_req = 1'b1;
        run_random(40);
        src_idle_en = 1'b1;
        run_random(30);
    endtask

    task automatic test_random_settings();
        repeat (2)
        begin
            apply_settings(svwm_pkg::CFG_DATA_W'($urandom_range(0, 3)),
                           svwm_pkg::CFG_DATA_W'($urandom_range(0, 16500)),
                           svwm_pkg::CFG_DATA_W'($urandom_range(0, 16500)),
                           svwm_pkg::CFG_DATA_W'($urandom_range(0, 65535)),
                           svwm_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
            run_random(60);
        end
    endtask

    task automatic test_field_limits();
        apply_settings(svwm_pkg::CFG_DATA_W'(svwm_pkg::MODE_AUTO), 16'h7FFF, 16'd16500,
                       16'd1, 16'd1);
        run_random(40);
    endtask

    task automatic test_full_rate();
        apply_settings(svwm_pkg::CFG_DATA_W'(svwm_pkg::MODE_AUTO),
                       svwm_pkg::CFG_DATA_W'(svwm_pkg::AUTO_HIGH_RST),
                       svwm_pkg::CFG_DATA_W'(svwm_pkg::AUTO_LOW_RST),
                       svwm_pkg::MINOR_HOLDOFF_RST, svwm_pkg::MAJOR_HOLDOFF_RST);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        run_random(80);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.sample_mv = '0;
        in_ch.now_ticks = '0;
        reset_monitor_model();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_extremes();
        test_fixed_modes();
        test_zero_holdoff();
        test_threshold_extremes();
        test_backpressure();
        test_random_settings();
        test_field_limits();
        test_full_rate();

        settle_block();
        repeat (LATENCY + 5) @(posedge clk);
        if (expected_readings.size() != 0)
            report_mismatch("results still pending at end", 0, expected_readings.size());
        if (error_count == 0)
            $display("[supply_voltage_window_monitor] OK");
        else
            $display("[supply_voltage_window_monitor] ERROR");
        $finish;
    end

endmodule
